// ===== rtl/core/qhs_pkg.sv =====
// ----------------------------------------------------------------------------
// qhs_pkg
// Shared constants, types and helpers of the quality histogram statistics core.
// ----------------------------------------------------------------------------
package qhs_pkg;

	localparam int TOP_Q      = 63;
	localparam int NBINS      = TOP_Q + 1;
	localparam int BIN_W      = $clog2(NBINS);
	localparam int CNT_W      = 32;
	localparam int CUM_W      = CNT_W + BIN_W;
	localparam int SUM_W      = CNT_W + 2 * BIN_W;
	localparam int DVD_W      = SUM_W + 8;
	localparam int QUO_W      = 21;
	localparam int MEAN_W     = 14;
	localparam int MED_W      = 7;
	localparam int NRANKS     = 8;
	localparam int DIV_STEPS  = DVD_W;
	localparam int STEP_W     = 7;
	localparam int TDATA_W    = 88;
	localparam int RECIP_SH   = 35;

	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [CNT_W-1:0]  RECIP10  = 32'hCCCC_CCCD;
	localparam logic [MEAN_W-1:0] MEAN_CAP = 14'(TOP_Q * 256);

	// rank slots of the report walk
	localparam int RK_MED_A = 0;
	localparam int RK_MED_B = 1;
	localparam int RK_LQ_A  = 2;
	localparam int RK_LQ_B  = 3;
	localparam int RK_UQ_A  = 4;
	localparam int RK_UQ_B  = 5;
	localparam int RK_LC    = 6;
	localparam int RK_UC    = 7;

	typedef struct packed {
		logic             accept;
		logic             inc;
		logic             ten;
		logic             ranks;
		logic             rd_en;
		logic [BIN_W-1:0] rd_addr;
		logic             divi;
		logic             div_step;
		logic             load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_full;
	} sts_t;

	function automatic logic [BIN_W-1:0] clamp_q(input logic [7:0] q);
		return (q > 8'(TOP_Q)) ? BIN_W'(TOP_Q) : q[BIN_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== rtl/core/qhs_ram.sv =====
// ----------------------------------------------------------------------------
// qhs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/qhs_ctrl.sv =====
// ----------------------------------------------------------------------------
// qhs_ctrl
// Sequencer: sample update, report walk, mean division and result hand-off.
// ----------------------------------------------------------------------------
module qhs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qhs_pkg::sts_t sts,
	output qhs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE, INC, TEN, RANKS, WALK, DRAIN, DIVI, DIV_ST
	} state_t;

	state_t                      state_q;
	logic [qhs_pkg::STEP_W-1:0]  step_q;
	logic                        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (done_q) begin
						if (!sts.out_full) begin
							done_q <= 1'b0;
						end
					end else if (in_valid) begin
						state_q <= INC;
					end
				end
				INC: begin
					state_q <= sts.last ? TEN : IDLE;
				end
				TEN:   state_q <= RANKS;
				RANKS: begin
					state_q <= WALK;
					step_q  <= '0;
				end
				WALK: begin
					step_q <= step_q + 1'b1;
					if (step_q == qhs_pkg::STEP_W'(qhs_pkg::NBINS - 1)) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: state_q <= DIVI;
				DIVI: begin
					state_q <= DIV_ST;
					step_q  <= '0;
				end
				DIV_ST: begin
					step_q <= step_q + 1'b1;
					if (step_q == qhs_pkg::STEP_W'(qhs_pkg::DIV_STEPS - 1)) begin
						state_q <= IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// result waits in IDLE with done_q set until the output register is free
	assign in_ready = (state_q == IDLE) && !done_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = in_ready && in_valid;
		cmd.inc      = (state_q == INC);
		cmd.ten      = (state_q == TEN);
		cmd.ranks    = (state_q == RANKS);
		cmd.rd_en    = (state_q == WALK);
		cmd.rd_addr  = step_q[qhs_pkg::BIN_W-1:0];
		cmd.divi     = (state_q == DIVI);
		cmd.div_step = (state_q == DIV_ST);
		cmd.load     = (state_q == IDLE) && done_q && !sts.out_full;
	end

endmodule

// ===== rtl/core/qhs_dp.sv =====
// ----------------------------------------------------------------------------
// qhs_dp
// Datapath: histogram RAM, totals, rank walk, mean divider, result register.
// ----------------------------------------------------------------------------
module qhs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qhs_pkg::cmd_t                 cmd,
	input  logic [7:0]                    in_quality,
	input  logic                          in_last,
	output qhs_pkg::sts_t                 sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [qhs_pkg::TDATA_W-1:0]   out_data,
	output logic                          out_user
);

	localparam int CW = qhs_pkg::CNT_W;
	localparam int BW = qhs_pkg::BIN_W;

	logic [BW-1:0]              qual_q;
	logic                       last_q;
	logic [CW-1:0]              total_q;
	logic [qhs_pkg::NBINS-1:0]  vld_q;
	logic                       rd_vld_s1;
	logic [CW-1:0]              ram_q;
	logic [CW-1:0]              word;
	logic [BW-1:0]              ram_raddr;
	logic                       ram_re;
	logic [2*CW-1:0]            prod_q;
	logic [CW-1:0]              tenth;
	logic [CW-1:0]              half;
	logic [CW-1:0]              rank_q [qhs_pkg::NRANKS];
	logic                       med_nz_q, lq_nz_q, uq_nz_q;
	logic                       walk_s1;
	logic [BW-1:0]              bin_s1;
	logic [qhs_pkg::CUM_W-1:0]  cum_q, cum_nx;
	logic [qhs_pkg::SUM_W-1:0]  sum_q;
	logic [qhs_pkg::CUM_W-1:0]  bin_prod;
	logic [CW-1:0]              best_q;
	logic [BW-1:0]              mode_q;
	logic [qhs_pkg::NRANKS-1:0] fnd_q;
	logic [BW-1:0]              val_q [qhs_pkg::NRANKS];
	logic [qhs_pkg::DVD_W-1:0]  dvd_q;
	logic [CW-1:0]              rem_q;
	logic [CW:0]                rem_sh;
	logic [qhs_pkg::QUO_W-1:0]  quo_q;
	logic [BW-1:0]              qv [qhs_pkg::NRANKS];
	logic [qhs_pkg::MEAN_W-1:0] mean;
	logic [qhs_pkg::MED_W-1:0]  med, lq, uq;
	logic                       out_vld_q;

	assign ram_re    = cmd.accept || cmd.rd_en;
	assign ram_raddr = cmd.accept ? qhs_pkg::clamp_q(in_quality) : cmd.rd_addr;

	qhs_ram #(.WIDTH(CW), .DEPTH(qhs_pkg::NBINS)) u_hist (
		.clk   (clk),
		.we    (cmd.inc),
		.waddr (qual_q),
		.wdata (qhs_pkg::sat_inc(word)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_q)
	);

	// bins never written since the last clear read as zero
	assign word = rd_vld_s1 ? ram_q : '0;

	assign tenth = CW'(prod_q[2*CW-1:qhs_pkg::RECIP_SH]);
	assign half  = total_q >> 1;

	assign cum_nx   = cum_q + qhs_pkg::CUM_W'(word);
	assign bin_prod = qhs_pkg::CUM_W'(bin_s1) * qhs_pkg::CUM_W'(word);
	assign rem_sh   = {rem_q, dvd_q[qhs_pkg::DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			total_q   <= '0;
			walk_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			walk_s1 <= cmd.rd_en;
			if (cmd.inc) begin
				vld_q[qual_q] <= 1'b1;
				total_q       <= qhs_pkg::sat_inc(total_q);
			end
			if (cmd.load) begin
				vld_q     <= '0;
				total_q   <= '0;
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_vld_s1 <= vld_q[ram_raddr];
		end
		bin_s1 <= cmd.rd_addr;
		if (cmd.accept) begin
			qual_q <= qhs_pkg::clamp_q(in_quality);
			last_q <= in_last;
		end
		if (cmd.ten) begin
			prod_q <= (2*CW)'(total_q) * (2*CW)'(qhs_pkg::RECIP10);
		end
		if (cmd.ranks) begin
			rank_q[qhs_pkg::RK_MED_A] <= (total_q - 1'b1) >> 1;
			rank_q[qhs_pkg::RK_MED_B] <= total_q >> 1;
			rank_q[qhs_pkg::RK_LQ_A]  <= (half - 1'b1) >> 1;
			rank_q[qhs_pkg::RK_LQ_B]  <= half >> 1;
			rank_q[qhs_pkg::RK_UQ_A]  <= half + ((total_q - half - 1'b1) >> 1);
			rank_q[qhs_pkg::RK_UQ_B]  <= half + ((total_q - half) >> 1);
			rank_q[qhs_pkg::RK_LC]    <= tenth;
			rank_q[qhs_pkg::RK_UC]    <= total_q - tenth;
			med_nz_q <= (total_q != '0);
			lq_nz_q  <= (half != '0);
			uq_nz_q  <= (total_q != half);
			cum_q    <= '0;
			sum_q    <= '0;
			best_q   <= '0;
			mode_q   <= '0;
			fnd_q    <= '0;
		end
		if (walk_s1) begin
			cum_q <= cum_nx;
			sum_q <= sum_q + qhs_pkg::SUM_W'(bin_prod);
			if (bin_s1 != '0 && word > best_q) begin
				best_q <= word;
				mode_q <= bin_s1;
			end
			for (int k = 0; k < qhs_pkg::NRANKS; k++) begin
				if (!fnd_q[k] && qhs_pkg::CUM_W'(rank_q[k]) < cum_nx) begin
					fnd_q[k] <= 1'b1;
					val_q[k] <= bin_s1;
				end
			end
		end
		if (cmd.divi) begin
			dvd_q <= {sum_q, 8'd0};
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, total_q}) begin
				rem_q <= CW'(rem_sh - {1'b0, total_q});
				quo_q <= {quo_q[qhs_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CW-1:0];
				quo_q <= {quo_q[qhs_pkg::QUO_W-2:0], 1'b0};
			end
		end
		if (cmd.load) begin
			out_user <= (total_q == '0);
			if (total_q == '0) begin
				out_data <= '0;
			end else begin
				out_data <= {3'd0, qv[qhs_pkg::RK_UC], qv[qhs_pkg::RK_LC], uq, lq,
					mode_q, med, mean, total_q};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < qhs_pkg::NRANKS; k++) begin
			qv[k] = (fnd_q[k] && rank_q[k] < total_q) ? val_q[k] : '0;
		end
		med = med_nz_q ? (qhs_pkg::MED_W'(qv[qhs_pkg::RK_MED_A]) +
			qhs_pkg::MED_W'(qv[qhs_pkg::RK_MED_B])) : '0;
		lq = lq_nz_q ? (qhs_pkg::MED_W'(qv[qhs_pkg::RK_LQ_A]) +
			qhs_pkg::MED_W'(qv[qhs_pkg::RK_LQ_B])) : '0;
		uq = uq_nz_q ? (qhs_pkg::MED_W'(qv[qhs_pkg::RK_UQ_A]) +
			qhs_pkg::MED_W'(qv[qhs_pkg::RK_UQ_B])) : '0;
		mean = (quo_q > qhs_pkg::QUO_W'(qhs_pkg::MEAN_CAP)) ? qhs_pkg::MEAN_CAP :
			quo_q[qhs_pkg::MEAN_W-1:0];
	end

	assign sts.last     = last_q;
	assign sts.out_full = out_vld_q && !out_ready;
	assign out_valid    = out_vld_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(out_vld_q && !out_ready))
		else $error("result loaded over a pending result");
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (total_q == '0) && (vld_q == '0) && out_vld_q)
		else $error("report did not clear the histogram");
	a_inc_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inc |-> !cmd.accept && !walk_s1 && !cmd.rd_en)
		else $error("histogram update overlaps another access");

endmodule

// ===== rtl/core/quality_histogram_statistics_core.sv =====
// ----------------------------------------------------------------------------
// quality_histogram_statistics_core
// Counts clamped quality scores in a 64-bin histogram and reports count, mean,
// median, quartiles, mode and 10%/90% centiles when a last sample arrives.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                   | tuser     | tlast
//  --------+-----------+-------------------------+-----------+-------------
//  s_*     | in        | [7:0] quality           | -         | last sample
//  m_*     | out       | statistics, see port    | empty_res | -
//
//  A sample that is not last is a RAM read, then a saturating write.
//  A last sample adds the report: tenth multiply, rank setup, a walk over
//  the 64 bins through the RAM read port plus a drain step, divider load
//  and the one-bit-per-cycle mean divider.
//  Reset clears the per-bin valid bits at once; no clearing pass is needed.
//  A finished result sits in the output register; the next sample is taken
//  while it waits, and only the next report stalls until it is taken.
//
module quality_histogram_statistics_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] quality
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] sample_count, [45:32] mean_q8, [52:46] median_x2,
	// [58:53] mode_quality, [65:59] lower_quartile_x2, [72:66] upper_quartile_x2,
	// [78:73] p10_quality, [84:79] p90_quality, [87:85] zero
	output logic [qhs_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tuser    // [0] empty_res
);

	qhs_pkg::cmd_t cmd;
	qhs_pkg::sts_t sts;

	// sequencer: owns state, walk and divider step counts
	qhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: histogram, accumulators and result register
	qhs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_quality (s_tdata),
		.in_last    (s_tlast),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata),
		.out_user   (m_tuser)
	);

endmodule
